// ----- design/ggm_level_expand_aes_assert.svh -----
// Assertion macros for the GGM level expander.
`ifndef GGM_LEVEL_EXPAND_AES_ASSERT_SVH
`define GGM_LEVEL_EXPAND_AES_ASSERT_SVH
`ifndef SYNTHESIS
`define GLE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gle assertion failed");
`define GLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gle assertion failed");
`else
`define GLE_ASSERT(lbl, clk, rst_n, prop)
`define GLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/gle_pkg.sv -----
`default_nettype none
package gle_pkg;

    localparam int unsigned HALF_W  = 64;
    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned ROUNDS  = 10;
    localparam logic [7:0]  RCON_FIRST = 8'h01;

    // one word moving down the round chain
    typedef struct packed {
        logic               valid;
        logic               mode;
        logic               last;
        logic [7:0]         rcon;
        logic [BLOCK_W-1:0] key;
        logic [BLOCK_W-1:0] s0;
        logic [BLOCK_W-1:0] s1;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] f_xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // SubBytes followed by ShiftRows; byte i sits at bits 8i+7..8i
    function automatic logic [BLOCK_W-1:0] f_sub_shift(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] n;
        int unsigned        row;
        int unsigned        col;
        int unsigned        src;
        n = '0;
        for (int unsigned i = 0; i < 16; i++) begin
            row = i % 4;
            col = i / 4;
            src = row + 4 * ((col + row) % 4);
            n[8*i +: 8] = SBOX[s[8*src +: 8]];
        end
        return n;
    endfunction

    function automatic logic [BLOCK_W-1:0] f_mix(input logic [BLOCK_W-1:0] n);
        logic [BLOCK_W-1:0] m;
        logic [7:0]         a0, a1, a2, a3, t;
        m = '0;
        for (int unsigned c = 0; c < 4; c++) begin
            a0 = n[32*c +: 8];
            a1 = n[32*c + 8 +: 8];
            a2 = n[32*c + 16 +: 8];
            a3 = n[32*c + 24 +: 8];
            t  = a0 ^ a1 ^ a2 ^ a3;
            m[32*c +: 8]      = a0 ^ t ^ f_xtime(a0 ^ a1);
            m[32*c + 8 +: 8]  = a1 ^ t ^ f_xtime(a1 ^ a2);
            m[32*c + 16 +: 8] = a2 ^ t ^ f_xtime(a2 ^ a3);
            m[32*c + 24 +: 8] = a3 ^ t ^ f_xtime(a3 ^ a0);
        end
        return m;
    endfunction

    function automatic logic [BLOCK_W-1:0] f_key_next(input logic [BLOCK_W-1:0] k,
                                                      input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {k[103:96], k[127:104]};
        for (int unsigned j = 0; j < 4; j++) begin
            t[8*j +: 8] = SBOX[t[8*j +: 8]];
        end
        t[7:0] = t[7:0] ^ rcon;
        w0 = k[31:0] ^ t;
        w1 = k[63:32] ^ w0;
        w2 = k[95:64] ^ w1;
        w3 = k[127:96] ^ w2;
        return {w3, w2, w1, w0};
    endfunction

endpackage
`default_nettype wire

// ----- design/gle_round_cell.sv -----
`default_nettype none
module gle_round_cell #(
    parameter bit P_FINAL = 1'b0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire gle_pkg::t_stage i_stage,
    output gle_pkg::t_stage      o_stage
);
    import gle_pkg::*;

    t_stage             r_q;
    t_stage             n_q;
    logic [BLOCK_W-1:0] rk;
    logic [BLOCK_W-1:0] ss0;
    logic [BLOCK_W-1:0] ss1;

    // derive this round key and run both blocks through one round
    always_comb begin
        rk  = f_key_next(i_stage.key, i_stage.rcon);
        ss0 = f_sub_shift(i_stage.s0);
        ss1 = f_sub_shift(i_stage.s1);
        n_q = i_stage;
        n_q.rcon = f_xtime(i_stage.rcon);
        n_q.key  = rk;
        n_q.s0   = (P_FINAL ? ss0 : f_mix(ss0)) ^ rk;
        n_q.s1   = (P_FINAL ? ss1 : f_mix(ss1)) ^ rk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_stage = r_q;
endmodule
`default_nettype wire

// ----- design/gle_emit.sv -----
`default_nettype none
module gle_emit (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire gle_pkg::t_stage i_stage,
    output logic                 o_load_ok,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    output logic [263:0]         m_axis_tdata,
    output logic                 m_axis_tlast,
    output logic                 m_axis_tuser
);
    import gle_pkg::*;
    `include "ggm_level_expand_aes_assert.svh"

    t_stage             r_hold;
    logic               r_side;
    logic [HALF_W-1:0]  r_acc_lo [2];
    logic [HALF_W-1:0]  r_acc_hi [2];
    logic [1:0]         r_acc_c;
    logic [BLOCK_W-1:0] child;
    logic [HALF_W-1:0]  mlo;
    logic [HALF_W-1:0]  xor_lo;
    logic [HALF_W-1:0]  xor_hi;
    logic               ctl_nxt;
    logic               ctl_out;
    logic               fire;

    assign fire      = m_axis_tvalid && m_axis_tready;
    assign o_load_ok = !r_hold.valid || (r_side && m_axis_tready);

    always_comb begin
        child   = r_side ? r_hold.s1 : r_hold.s0;
        mlo     = r_hold.mode ? {child[HALF_W-1:1], 1'b0} : child[HALF_W-1:0];
        xor_lo  = r_acc_lo[r_side] ^ mlo;
        xor_hi  = r_acc_hi[r_side] ^ child[BLOCK_W-1:HALF_W];
        ctl_nxt = r_acc_c[r_side] ^ child[0];
        ctl_out = r_hold.mode & ctl_nxt;
    end

    // hold a child pair; send left, then right
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.valid <= 1'b0;
            r_side       <= 1'b0;
            r_acc_lo[0]  <= '0;
            r_acc_lo[1]  <= '0;
            r_acc_hi[0]  <= '0;
            r_acc_hi[1]  <= '0;
            r_acc_c      <= '0;
        end else begin
            if (o_load_ok) begin
                r_hold <= i_stage;
                r_side <= 1'b0;
            end else if (fire) begin
                r_side <= 1'b1;
            end
            if (fire) begin
                if (r_side && r_hold.last) begin
                    r_acc_lo[0] <= '0;
                    r_acc_lo[1] <= '0;
                    r_acc_hi[0] <= '0;
                    r_acc_hi[1] <= '0;
                    r_acc_c     <= '0;
                end else begin
                    r_acc_lo[r_side] <= xor_lo;
                    r_acc_hi[r_side] <= xor_hi;
                    if (r_hold.mode) begin
                        r_acc_c[r_side] <= ctl_nxt;
                    end
                end
            end
        end
    end

    assign m_axis_tvalid = r_hold.valid;
    assign m_axis_tdata  = {7'd0, ctl_out, xor_hi, xor_lo, child};
    assign m_axis_tlast  = r_hold.last;
    assign m_axis_tuser  = r_side;

    `GLE_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !r_hold.valid |-> o_load_ok)
    `GLE_ASSERT_NEXT(a_left_then_right, i_clk, i_rst_n, fire && !r_side, r_hold.valid && r_side)
    `GLE_ASSERT(a_mode0_no_ctl, i_clk, i_rst_n, (r_hold.valid && !r_hold.mode) |-> !ctl_out)
    `GLE_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n, fire && r_side && r_hold.last, r_acc_lo[0] == '0 && r_acc_hi[1] == '0 && r_acc_c == '0)
endmodule
`default_nettype wire

// ----- design/ggm_level_expand_aes.sv -----
// Channel   Dir  Word contents (lowest bit first)
// s_axis    in   tdata: node_lo[63:0], node_hi[127:64]; tlast: last_node
// m_axis    out  tdata: child_lo, child_hi, xor_lo, xor_hi, control_xor, zero pad;
//                tuser: child_side; tlast: level_done
// cfg       in   i_cfg_wr_en / i_cfg_wr_data: level_mode
//
// Each node passes a key-load stage and ten AES round cells, then a
// child holder that sends the left and the right child as two words.
// The one output channel bounds throughput: a held node gives way only as its right child is sent.
// Reset (synchronous, active low) clears valids, accumulators and level_mode.
// A stall on m_axis freezes the whole round chain; s_axis_tready follows it.
`default_nettype none
module ggm_level_expand_aes (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic          i_cfg_wr_data,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [127:0]  s_axis_tdata,   // node_lo, node_hi
    input  wire logic          s_axis_tlast,   // last_node
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [263:0]       m_axis_tdata,   // child_lo, child_hi, xor_lo, xor_hi, control_xor
    output logic               m_axis_tlast,   // level_done
    output logic               m_axis_tuser    // child_side
);
    import gle_pkg::*;

    logic               r_level_mode;
    t_stage             r_load;
    t_stage             n_load;
    t_stage             chain [ROUNDS+1];
    logic               adv;
    logic [BLOCK_W-1:0] key;

    // level_mode: to be written only while idle; the user must ensure this, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_level_mode <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = adv;

    // key load: clear the key bit in mode 1, whiten plaintexts 0 and 1
    always_comb begin
        key = s_axis_tdata;
        if (r_level_mode) begin
            key[0] = 1'b0;
        end
        n_load.valid = s_axis_tvalid;
        n_load.mode  = r_level_mode;
        n_load.last  = s_axis_tlast;
        n_load.rcon  = RCON_FIRST;
        n_load.key   = key;
        n_load.s0    = key;
        n_load.s1    = {key[BLOCK_W-1:1], ~key[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load.valid <= 1'b0;
        end else if (adv) begin
            r_load <= n_load;
        end
    end

    assign chain[0] = r_load;

    // ten round cells; advance all together
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        gle_round_cell #(
            .P_FINAL(g == ROUNDS - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    gle_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stage       (chain[ROUNDS]),
        .o_load_ok     (adv),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );
endmodule
`default_nettype wire
